// File: design/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// rrfp_pkg
// shared types and constants for the register response frame parser
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam int DEF_MAX_DATA_BYTES = 32;

  localparam logic [7:0] HDR0      = 8'hEE;
  localparam logic [7:0] HDR1      = 8'h16;
  localparam logic [7:0] CMD_READ  = 8'h00;
  localparam logic [7:0] CMD_WRITE = 8'h01;

  localparam logic [1:0] STAT_VALUE   = 2'd0;
  localparam logic [1:0] STAT_ACK     = 2'd1;
  localparam logic [1:0] STAT_NOVAL   = 2'd2;
  localparam logic [1:0] STAT_TOOLONG = 2'd3;

  typedef enum logic [3:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_ID,
    PH_LEN,
    PH_CMD,
    PH_BODY,
    PH_SKIP,
    PH_EMIT_RD,
    PH_EMIT_LD
  } phase_t;

  // one result handed to the output register
  typedef struct packed {
    logic        load;
    logic [1:0]  status;
    logic [15:0] value;
    logic        last;
  } rrfp_res_t;

endpackage

// File: design/rrfp_store.sv
// ----------------------------------------------------------------------------
// rrfp_store
// payload buffer: 16-bit words with byte lane writes, registered read
// ----------------------------------------------------------------------------
module rrfp_store
  import rrfp_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES,
  localparam int WORDS  = (MAX_DATA_BYTES + 1) / 2,
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic                wr_hi,
  input  logic [7:0]          wr_byte,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [15:0]         rd_data
);

  logic [15:0] mem_r [WORDS];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_hi) begin
        mem_r[wr_addr][15:8] <= wr_byte;
      end else begin
        mem_r[wr_addr][7:0] <= wr_byte;
      end
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/rrfp_parser.sv
// ----------------------------------------------------------------------------
// rrfp_parser
// frame sequencer: header hunt, field decode, checksum, buffer fill and readout
// ----------------------------------------------------------------------------
module rrfp_parser
  import rrfp_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES,
  localparam int WORDS  = (MAX_DATA_BYTES + 1) / 2,
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_rx_byte,
  output logic              in_stall,
  input  logic [7:0]        device_id,
  input  logic              out_free,
  output rrfp_res_t         res,
  output logic              mem_wr_en,
  output logic [ADDR_W-1:0] mem_wr_addr,
  output logic              mem_wr_hi,
  output logic              mem_rd_en,
  output logic [ADDR_W-1:0] mem_rd_addr,
  input  logic [15:0]       mem_rd_data
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic       is_write_r, is_write_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       id_mis_r, id_mis_nxt;
  logic [6:0] idx_r, idx_nxt;

  logic       accept;
  logic       emitting;
  logic [7:0] sum_add;
  logic [8:0] cnt_inc;
  logic [8:0] body_total;
  logic       body_last;
  logic       sum_ok;
  logic [6:0] nval;
  logic [7:0] data_idx;
  logic       store_ok;
  logic       idx_last;
  logic       reject;
  logic       too_long;
  logic       skip_done;

  assign emitting   = (phase_r == PH_EMIT_RD) || (phase_r == PH_EMIT_LD);
  assign in_stall   = emitting || !out_free;
  assign accept     = in_valid && !in_stall;

  assign sum_add    = sum_r + in_rx_byte;
  assign cnt_inc    = {1'b0, cnt_r} + 9'd1;
  assign body_total = is_write_r ? 9'd4 : {1'b0, len_r};
  assign body_last  = cnt_inc >= body_total;
  assign sum_ok     = in_rx_byte == sum_r;
  assign nval       = 7'((len_r - 8'd3) >> 1);
  assign data_idx   = cnt_r - 8'd2;
  assign store_ok   = !is_write_r && (cnt_r >= 8'd2) &&
                      ({1'b0, data_idx} < 9'(MAX_DATA_BYTES));
  assign idx_last   = ({1'b0, idx_r} + 8'd1) == {1'b0, nval};
  assign reject     = ((in_rx_byte != CMD_READ) && (in_rx_byte != CMD_WRITE)) ||
                      id_mis_r || ((in_rx_byte == CMD_READ) && (len_r < 8'd3));
  assign too_long   = {1'b0, len_r} > 9'(MAX_DATA_BYTES + 3);
  assign skip_done  = cnt_inc[7:0] >= len_r;

  // next state and datapath
  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    is_write_nxt = is_write_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    id_mis_nxt   = id_mis_r;
    idx_nxt      = idx_r;
    case (phase_r)
      PH_HUNT0: begin
        if (accept && (in_rx_byte == HDR0)) begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_HUNT1: begin
        if (accept) begin
          if (in_rx_byte == HDR1) begin
            phase_nxt = PH_ID;
          end else if (in_rx_byte != HDR0) begin
            phase_nxt = PH_HUNT0;
          end
        end
      end
      PH_ID: begin
        if (accept) begin
          id_mis_nxt = (device_id != 8'd0) && (in_rx_byte != device_id);
          sum_nxt    = in_rx_byte;
          phase_nxt  = PH_LEN;
        end
      end
      PH_LEN: begin
        if (accept) begin
          len_nxt   = in_rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        if (accept) begin
          sum_nxt = sum_add;
          cnt_nxt = 8'd0;
          if (reject) begin
            phase_nxt = PH_HUNT0;
          end else begin
            is_write_nxt = (in_rx_byte == CMD_WRITE);
            if ((in_rx_byte != CMD_WRITE) && too_long) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      PH_SKIP: begin
        if (accept) begin
          cnt_nxt = cnt_inc[7:0];
          if (skip_done) begin
            phase_nxt = PH_HUNT0;
          end
        end
      end
      PH_BODY: begin
        if (accept) begin
          if (body_last) begin
            phase_nxt = PH_HUNT0;
            if (sum_ok && !is_write_r && (len_r >= 8'd4) && (nval != 7'd0)) begin
              idx_nxt   = 7'd0;
              phase_nxt = PH_EMIT_RD;
            end
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_inc[7:0];
          end
        end
      end
      PH_EMIT_RD: begin
        phase_nxt = PH_EMIT_LD;
      end
      PH_EMIT_LD: begin
        if (out_free) begin
          if (idx_last) begin
            phase_nxt = PH_HUNT0;
          end else begin
            idx_nxt   = idx_r + 7'd1;
            phase_nxt = PH_EMIT_RD;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT0;
      end
    endcase
  end

  // results and buffer accesses
  always_comb begin
    res         = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = data_idx[ADDR_W:1];
    mem_wr_hi   = data_idx[0];
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r[ADDR_W-1:0];
    case (phase_r)
      PH_SKIP: begin
        if (accept && skip_done) begin
          res.load   = 1'b1;
          res.status = STAT_TOOLONG;
          res.last   = 1'b1;
        end
      end
      PH_BODY: begin
        if (accept && body_last && sum_ok) begin
          if (is_write_r) begin
            res.load   = 1'b1;
            res.status = STAT_ACK;
            res.last   = 1'b1;
          end else if ((len_r >= 8'd4) && (nval == 7'd0)) begin
            res.load   = 1'b1;
            res.status = STAT_NOVAL;
            res.last   = 1'b1;
          end
        end
        if (accept && !body_last && store_ok) begin
          mem_wr_en = 1'b1;
        end
      end
      PH_EMIT_RD: begin
        mem_rd_en = 1'b1;
      end
      PH_EMIT_LD: begin
        if (out_free) begin
          res.load   = 1'b1;
          res.status = STAT_VALUE;
          res.value  = mem_rd_data;
          res.last   = idx_last;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT0;
      len_r      <= 8'd0;
      is_write_r <= 1'b0;
      cnt_r      <= 8'd0;
      sum_r      <= 8'd0;
      id_mis_r   <= 1'b0;
      idx_r      <= 7'd0;
    end else begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      is_write_r <= is_write_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      id_mis_r   <= id_mis_nxt;
      idx_r      <= idx_nxt;
    end
  end

endmodule

// File: design/register_response_frame_parser_top.sv
// ----------------------------------------------------------------------------
// register_response_frame_parser_top
// deframer for register response frames with an 8-bit additive checksum
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one received byte per transfer (in_valid / in_stall)
//   out_* : one result per transfer: status, signed 16-bit value, last flag
//   cfg_* : cfg_wr_en writes cfg_device_id; zero accepts any responder id
// throughput and result timing:
//   while a frame streams in and the output slot is free, one byte is taken
//   every cycle; a result for an ack, a too-long frame or an empty read is
//   registered and shows up in the cycle after the checksum byte
//   after a good read frame with values, input is held off while the buffer
//   is read out: for each value one payload memory read, then one load of the
//   output register
// stall behavior:
//   the output register parts the channels; a byte is taken while a result
//   waits as long as the receiver is taking it in the same cycle, otherwise
//   in_stall rises and the parser holds
// reset:
//   synchronous, active low; back to hunting the first header byte, device id
//   cleared, output empty; the payload buffer is not cleared (it is always
//   written before it is read within a frame)
// ----------------------------------------------------------------------------
module register_response_frame_parser_top
  import rrfp_pkg::*;
#(
  parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  output logic               in_stall,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_value,
  output logic               out_last,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_device_id
);

  localparam int WORDS  = (MAX_DATA_BYTES + 1) / 2;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic              device_id_r;
  logic [7:0]        dev_id_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [15:0]       out_value_r;
  logic              out_last_r;
  logic              out_free;
  rrfp_res_t         res;

  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic              mem_wr_hi;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [15:0]       mem_rd_data;

  // device id register; the user writes it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r    <= 8'd0;
      device_id_r <= 1'b0;
    end else if (cfg_wr_en) begin
      dev_id_r    <= cfg_device_id;
      device_id_r <= (cfg_device_id != 8'd0);
    end
  end

  // output slot frees up when empty or drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  rrfp_parser #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_rx_byte  (in_rx_byte),
    .in_stall    (in_stall),
    .device_id   (device_id_r ? dev_id_r : 8'd0),
    .out_free    (out_free),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_hi   (mem_wr_hi),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // payload buffer; writes come only during the frame body and reads only
  // afterwards, so the same word is never written and read in one cycle
  rrfp_store #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_hi   (mem_wr_hi),
    .wr_byte (in_rx_byte),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
      out_last_r   <= res.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

// File: design/rrfp_checker.sv
// ----------------------------------------------------------------------------
// rrfp_checker
// port level checks for the register response frame parser
// ----------------------------------------------------------------------------
module rrfp_checker
  import rrfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [15:0] out_value,
  input logic        out_last
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // only value results can be followed by more results of the same frame
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_VALUE) |-> out_last)
    else $error("non-value result without last");

  // non-value results carry zero
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_VALUE) |-> (out_value == 16'd0))
    else $error("non-value result with nonzero value");

  // no byte taken while a result is blocked at the output
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

endmodule

bind register_response_frame_parser_top rrfp_checker u_rrfp_checker (.*);

// File: tb/rrfp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_tb_pkg
// byte-level predictor and result scoreboard for the frame parser testbench
// ----------------------------------------------------------------------------
package rrfp_tb_pkg;
  import rrfp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] value;
    logic               last;
  } frame_result_t;

  class response_frame_scoreboard;
    logic [7:0]    device_id;
    phase_t        parse_phase;
    logic [7:0]    length_field;
    logic [7:0]    body_count;
    logic [7:0]    running_sum;
    bit            is_write;
    bit            id_mismatch;
    logic [7:0]    payload [DEF_MAX_DATA_BYTES];
    frame_result_t expected_results [$];
    int            failures;

    function new();
      device_id    = 8'h00;
      parse_phase  = PH_HUNT0;
      length_field = 8'h00;
      body_count   = 8'h00;
      running_sum  = 8'h00;
      is_write     = 1'b0;
      id_mismatch  = 1'b0;
      failures     = 0;
      foreach (payload[i]) payload[i] = 8'h00;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void push_expected(logic [1:0] status, logic [15:0] value, logic last);
      frame_result_t r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      expected_results = {expected_results, r};
    endfunction

    // advance the parser state by one accepted byte, queue what it yields
    function void take_rx_byte(logic [7:0] b);
      int total;
      int nval;
      case (parse_phase)
        PH_HUNT0: if (b == HDR0) parse_phase = PH_HUNT1;
        PH_HUNT1: begin
          if (b == HDR1) parse_phase = PH_ID;
          else if (b != HDR0) parse_phase = PH_HUNT0;
        end
        PH_ID: begin
          id_mismatch = (device_id != 8'h00) && (b != device_id);
          running_sum = b;
          parse_phase = PH_LEN;
        end
        PH_LEN: begin
          length_field = b;
          running_sum  = running_sum + b;
          parse_phase  = PH_CMD;
        end
        PH_CMD: begin
          running_sum = running_sum + b;
          body_count  = 8'h00;
          if ((b != CMD_READ && b != CMD_WRITE) || id_mismatch ||
              (b == CMD_READ && length_field < 8'd3)) begin
            parse_phase = PH_HUNT0;
          end else begin
            is_write = (b == CMD_WRITE);
            if (!is_write && int'(length_field) - 3 > DEF_MAX_DATA_BYTES)
              parse_phase = PH_SKIP;
            else
              parse_phase = PH_BODY;
          end
        end
        PH_SKIP: begin
          body_count = body_count + 8'd1;
          if (body_count >= length_field) begin
            push_expected(STAT_TOOLONG, 16'h0000, 1'b1);
            parse_phase = PH_HUNT0;
          end
        end
        PH_BODY: begin
          total = is_write ? 4 : int'(length_field);
          if (int'(body_count) + 1 >= total) begin
            // checksum byte closes the frame
            parse_phase = PH_HUNT0;
            if (b == running_sum) begin
              if (is_write) begin
                push_expected(STAT_ACK, 16'h0000, 1'b1);
              end else if (length_field >= 8'd4) begin
                nval = (int'(length_field) - 3) / 2;
                if (nval == 0) push_expected(STAT_NOVAL, 16'h0000, 1'b1);
                for (int i = 0; i < nval; i++)
                  push_expected(STAT_VALUE, {payload[2*i+1], payload[2*i]}, i + 1 == nval);
              end
            end
          end else begin
            if (!is_write && body_count >= 8'd2 &&
                int'(body_count) - 2 < DEF_MAX_DATA_BYTES)
              payload[int'(body_count) - 2] = b;
            running_sum = running_sum + b;
            body_count  = body_count + 8'd1;
          end
        end
        default: parse_phase = PH_HUNT0;
      endcase
    endfunction

    function void check_result(logic [1:0] status, logic signed [15:0] value, logic last);
      frame_result_t e;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result status=%0d value=%0d last=%0d",
                       status, value, last));
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status || value !== e.value || last !== e.last)
        flag($sformatf("exp status=%0d value=%0d last=%0d, got status=%0d value=%0d last=%0d",
                       e.status, e.value, e.last, status, value, last));
    endfunction
  endclass

endpackage

// File: tb/tb_register_response_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_response_frame_parser_top
// feeds byte streams of good, damaged and rejected frames plus line noise into
// the parser under random handshake pressure, predicts every result from the
// byte stream and checks each one in order; device id is changed while idle
// ----------------------------------------------------------------------------
module tb_register_response_frame_parser_top;
  import rrfp_pkg::*;
  import rrfp_tb_pkg::*;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic [7:0]         in_rx_byte    = 8'h00;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [1:0]         out_status;
  logic signed [15:0] out_value;
  logic               out_last;
  logic               cfg_wr_en     = 1'b0;
  logic [7:0]         cfg_device_id = 8'h00;

  // idle chances in percent per cycle for sender and receiver
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  // every byte taken by the block so far
  int bytes_sent = 0;

  response_frame_scoreboard sb;

  register_response_frame_parser_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_rx_byte    (in_rx_byte),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value     (out_value),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_device_id (cfg_device_id)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_value, out_last);
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // hard stop in case the parser hangs or drops results
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // one byte transfer; valid stays high on return so back-to-back bytes
  // never lower and raise it in the same step
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer took place at this edge
    sb.take_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // header, id, length, command, body, then the additive checksum
  function automatic byte_q_t build_frame(logic [7:0] id, logic [7:0] len, logic [7:0] cmd,
                                          byte_q_t body, bit bad_sum);
    byte_q_t    q;
    logic [7:0] sum;
    sum = id + len + cmd;
    foreach (body[i]) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    q = {HDR0, HDR1, id, len, cmd};
    foreach (body[i]) q = {q, body[i]};
    q = {q, sum};
    return q;
  endfunction

  // mostly the configured id, sometimes any id
  function automatic logic [7:0] pick_id();
    if (sb.device_id == 8'h00 || $urandom_range(9) == 0)
      return 8'($urandom_range(255));
    return sb.device_id;
  endfunction

  // park the parser in header hunt, let all results drain, then write the id
  task automatic settle_and_configure(input logic [7:0] dev);
    // zero bytes walk any open frame to its end
    while (sb.parse_phase != PH_HUNT0) send_byte(8'h00);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // parser may still be busy with a frame that gives no result
    repeat (8) @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_device_id <= dev;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    sb.device_id = dev;
  endtask

  task automatic send_random_frame();
    byte_q_t    body;
    byte_q_t    q;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] cmd;
    int         kind;
    int         sel;
    int         size_pick;
    int         ndata;
    int         nbody;
    bit         bad_sum;
    kind      = $urandom_range(99);
    sel       = $urandom_range(99);
    size_pick = $urandom_range(99);
    bad_sum   = 1'b0;
    if (kind >= 94) begin
      // line noise with header bytes now and then
      repeat ($urandom_range(1, 6)) begin
        sel = $urandom_range(99);
        send_byte(sel < 30 ? HDR0 : (sel < 45 ? HDR1 : 8'($urandom_range(255))));
      end
      return;
    end
    id  = pick_id();
    cmd = CMD_READ;
    // mostly small reads, some up to a full buffer, a few too long
    if (size_pick < 75)
      ndata = $urandom_range(1, 8);
    else if (size_pick < 92)
      ndata = $urandom_range(9, DEF_MAX_DATA_BYTES);
    else
      ndata = $urandom_range(DEF_MAX_DATA_BYTES + 1, DEF_MAX_DATA_BYTES + 8);
    len = 8'(ndata + 3);
    if ((kind >= 42 && kind < 62) || (kind >= 62 && kind < 72 && sel < 50)) begin
      cmd = CMD_WRITE;
      // write length field is not checked by the parser
      len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'd9;
    end
    // damaged checksum
    if (kind >= 62 && kind < 72) bad_sum = 1'b1;
    // length 3 read is one byte short and can never pass
    if (kind >= 72 && kind < 78) len = 8'd3;
    nbody = (cmd == CMD_WRITE) ? 3 : int'(len) - 1;
    if (kind >= 78 && kind < 88) begin
      // rejected at the command byte
      nbody = $urandom_range(0, 3);
      if (sel < 40)
        cmd = 8'($urandom_range(2, 255));
      else if (sel < 70 && sb.device_id != 8'h00)
        id = sb.device_id ^ 8'($urandom_range(1, 255));
      else
        len = 8'($urandom_range(0, 2));
    end
    repeat (nbody) body = {body, 8'($urandom_range(255))};
    q = build_frame(id, len, cmd, body, bad_sum);
    // frame broken off part way
    if (kind >= 88) q = q[0 : $urandom_range(0, q.size() - 2)];
    send_bytes(q);
  endtask

  initial begin : stimulus
    byte_q_t    body;
    logic [7:0] dev_plan [6];
    sb = new();
    dev_plan = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), 8'h01,
                 8'($urandom_range(255)), 8'h00};
    in_idle_pct  = 34;
    out_idle_pct = 67;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settle_and_configure(8'h00);

    // directed: repeated first header byte, then a read with both value extremes
    send_byte(HDR0);
    body = {8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F};
    send_bytes(build_frame(8'h00, 8'd7, CMD_READ, body, 1'b0));
    // write with all-ones bytes
    body = {8'hFF, 8'hFF, 8'hFF};
    send_bytes(build_frame(8'hFF, 8'd9, CMD_WRITE, body, 1'b0));
    // one data byte only: empty read result
    body = {8'h12, 8'h34, 8'hA5};
    send_bytes(build_frame(8'h5A, 8'd4, CMD_READ, body, 1'b0));

    // random part: six blocks, each configured with a device id from dev_plan
    for (int blk = 0; blk < 6; blk++) begin
      if (blk == 2) begin
        in_idle_pct  = 67;
        out_idle_pct = 34;
      end
      if (blk == 4) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      settle_and_configure(dev_plan[blk]);
      while (bytes_sent < (blk + 1) * 77) send_random_frame();
    end

    // drain, then a short tail to catch extra results
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: register_response_frame_parser_top.f
design/rrfp_pkg.sv
design/rrfp_store.sv
design/rrfp_parser.sv
design/register_response_frame_parser_top.sv
design/rrfp_checker.sv
tb/rrfp_tb_pkg.sv
tb/tb_register_response_frame_parser_top.sv
